// ===== hw/rtl/imptab_pkg.sv =====
package imptab_pkg;

  localparam int OPCODE_BITS      = 3;
  localparam int ID_BITS          = 6;
  localparam int IN_PAYLOAD_BITS  = 32;
  localparam int OUT_PAYLOAD_BITS = 32;
  localparam int OUT_SCORE_BITS   = 16;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_ADD      = 3'd0,
    OP_PROMOTE  = 3'd1,
    OP_GET_MAX  = 3'd2,
    OP_POP_MAX  = 3'd3,
    OP_IS_VALID = 3'd4,
    OP_GET      = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DEAD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_LOOKUP,
    FSM_SCAN,
    FSM_FETCH
  } state_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]     opcode;
    logic [ID_BITS-1:0]         entry_id;
    logic [IN_PAYLOAD_BITS-1:0] payload;
  } in_beat_t;

  typedef struct packed {
    status_t                     status;
    logic [ID_BITS-1:0]          result_id;
    logic [OUT_PAYLOAD_BITS-1:0] result_payload;
    logic [OUT_SCORE_BITS-1:0]   result_score;
    logic                        is_live;
  } out_beat_t;

endpackage

// ===== hw/rtl/imptab_mem.sv =====
module imptab_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/indexed_max_priority_table.sv =====
// get max and pop max scan the ids issued so far, one score memory read per entry,
// and skip the scan when no id has been issued.
// one item at a time: busy drops in the strobe cycle, which may take the next beat, so
// an item occupies the block until its result strobe; the receiver cannot stall.
// sync active-low reset clears the fsm and id counter; ids at or above it are never live
module indexed_max_priority_table #(
  parameter int ENTRIES      = 64,
  parameter int PAYLOAD_BITS = 32,
  parameter int SCORE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  imptab_pkg::in_beat_t  in_cmd,
  output logic                  out_valid,
  output imptab_pkg::out_beat_t out_res
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int IDW  = imptab_pkg::ID_BITS;
  localparam int CMPW = (CW > IDW) ? CW : IDW;
  localparam int OPW  = imptab_pkg::OUT_PAYLOAD_BITS;
  localparam int OSW  = imptab_pkg::OUT_SCORE_BITS;

  imptab_pkg::state_t    state_r, state_nxt;
  imptab_pkg::in_beat_t  cmd_r;
  imptab_pkg::out_beat_t out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CW-1:0]         fresh_r, fresh_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]         data_idx_r;
  logic                  found_r, found_nxt;
  logic [AW-1:0]         best_id_r, best_id_nxt;
  logic [SCORE_BITS-1:0] best_score_r, best_score_nxt;

  logic                    sc_we;
  logic [AW-1:0]           sc_waddr, sc_raddr;
  logic [SCORE_BITS:0]     sc_wdata, sc_rdata;
  logic                    pay_we;
  logic [AW-1:0]           pay_waddr, pay_raddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;

  logic                  id_ok, full, sc_live, hit, take, cand_found, scan_more;
  logic [SCORE_BITS-1:0] sc_score, score_inc, cand_score;
  logic [AW-1:0]         cand_id, id_addr;

  // score memory word: {live, score}
  imptab_mem #(.WIDTH(SCORE_BITS + 1), .DEPTH(ENTRIES)) u_score_mem (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  imptab_mem #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_pay_mem (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  always_comb begin
    id_addr    = AW'(cmd_r.entry_id);
    id_ok      = CMPW'(cmd_r.entry_id) < CMPW'(fresh_r);
    full       = fresh_r == CW'(ENTRIES);
    sc_live    = sc_rdata[SCORE_BITS];
    sc_score   = sc_rdata[SCORE_BITS-1:0];
    hit        = id_ok && sc_live;
    score_inc  = (&sc_score) ? sc_score : sc_score + 1'b1;
    // ascending scan with >= hands ties to the greatest id
    take       = sc_live && (!found_r || sc_score >= best_score_r);
    cand_found = found_r || take;
    cand_id    = take ? data_idx_r : best_id_r;
    cand_score = take ? sc_score : best_score_r;
    scan_more  = rd_idx_r < fresh_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imptab_pkg::FSM_IDLE: begin
        if (start) begin
          state_nxt = imptab_pkg::FSM_DECODE;
        end
      end
      imptab_pkg::FSM_DECODE: begin
        unique case (cmd_r.opcode)
          imptab_pkg::OP_PROMOTE,
          imptab_pkg::OP_GET,
          imptab_pkg::OP_IS_VALID: state_nxt = imptab_pkg::FSM_LOOKUP;
          imptab_pkg::OP_GET_MAX,
          imptab_pkg::OP_POP_MAX: begin
            state_nxt = (fresh_r != '0) ? imptab_pkg::FSM_SCAN : imptab_pkg::FSM_IDLE;
          end
          default: state_nxt = imptab_pkg::FSM_IDLE;
        endcase
      end
      imptab_pkg::FSM_LOOKUP: state_nxt = imptab_pkg::FSM_IDLE;
      imptab_pkg::FSM_SCAN: begin
        if (!scan_more) begin
          state_nxt = cand_found ? imptab_pkg::FSM_FETCH : imptab_pkg::FSM_IDLE;
        end
      end
      imptab_pkg::FSM_FETCH: state_nxt = imptab_pkg::FSM_IDLE;
      default: state_nxt = imptab_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    out_nxt        = '0;
    out_valid_nxt  = 1'b0;
    fresh_nxt      = fresh_r;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_id_nxt    = best_id_r;
    best_score_nxt = best_score_r;
    sc_we          = 1'b0;
    sc_waddr       = id_addr;
    sc_wdata       = '0;
    sc_raddr       = id_addr;
    pay_we         = 1'b0;
    pay_waddr      = fresh_r[AW-1:0];
    pay_wdata      = PAYLOAD_BITS'(cmd_r.payload);
    pay_raddr      = id_addr;
    unique case (state_r)
      imptab_pkg::FSM_IDLE: ;
      imptab_pkg::FSM_DECODE: begin
        unique case (cmd_r.opcode)
          imptab_pkg::OP_ADD: begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_nxt.status = imptab_pkg::ST_FULL;
            end else begin
              pay_we            = 1'b1;
              sc_we             = 1'b1;
              sc_waddr          = fresh_r[AW-1:0];
              sc_wdata          = {1'b1, {SCORE_BITS{1'b0}}};
              fresh_nxt         = fresh_r + 1'b1;
              out_nxt.status    = imptab_pkg::ST_OK;
              out_nxt.result_id = IDW'(fresh_r);
              out_nxt.is_live   = 1'b1;
            end
          end
          imptab_pkg::OP_PROMOTE,
          imptab_pkg::OP_GET,
          imptab_pkg::OP_IS_VALID: ;
          imptab_pkg::OP_GET_MAX,
          imptab_pkg::OP_POP_MAX: begin
            if (fresh_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = imptab_pkg::ST_EMPTY;
            end else begin
              sc_raddr   = '0;
              rd_idx_nxt = CW'(1);
              found_nxt  = 1'b0;
            end
          end
          default: out_valid_nxt = 1'b1;
        endcase
      end
      imptab_pkg::FSM_LOOKUP: begin
        out_valid_nxt = 1'b1;
        if (cmd_r.opcode == imptab_pkg::OP_IS_VALID) begin
          out_nxt.status    = imptab_pkg::ST_OK;
          out_nxt.result_id = cmd_r.entry_id;
          out_nxt.is_live   = hit;
        end else if (!hit) begin
          out_nxt.status = imptab_pkg::ST_DEAD;
        end else begin
          out_nxt.status         = imptab_pkg::ST_OK;
          out_nxt.result_id      = cmd_r.entry_id;
          out_nxt.result_payload = OPW'(pay_rdata);
          out_nxt.result_score   = OSW'(sc_score);
          out_nxt.is_live        = 1'b1;
          if (cmd_r.opcode == imptab_pkg::OP_PROMOTE) begin
            sc_we                = 1'b1;
            sc_wdata             = {1'b1, score_inc};
            out_nxt.result_score = OSW'(score_inc);
          end
        end
      end
      imptab_pkg::FSM_SCAN: begin
        found_nxt      = cand_found;
        best_id_nxt    = cand_id;
        best_score_nxt = cand_score;
        if (scan_more) begin
          sc_raddr   = rd_idx_r[AW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else if (cand_found) begin
          pay_raddr = cand_id;
          if (cmd_r.opcode == imptab_pkg::OP_POP_MAX) begin
            sc_we    = 1'b1;
            sc_waddr = cand_id;
            sc_wdata = {1'b0, cand_score};
          end
        end else begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = imptab_pkg::ST_EMPTY;
        end
      end
      imptab_pkg::FSM_FETCH: begin
        out_valid_nxt          = 1'b1;
        out_nxt.status         = imptab_pkg::ST_OK;
        out_nxt.result_id      = IDW'(best_id_r);
        out_nxt.result_payload = OPW'(pay_rdata);
        out_nxt.result_score   = OSW'(best_score_r);
        out_nxt.is_live        = cmd_r.opcode != imptab_pkg::OP_POP_MAX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imptab_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
      fresh_r     <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fresh_r     <= fresh_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == imptab_pkg::FSM_IDLE) begin
      cmd_r <= in_cmd;
    end
    out_r        <= out_nxt;
    rd_idx_r     <= rd_idx_nxt;
    data_idx_r   <= sc_raddr;
    best_id_r    <= best_id_nxt;
    best_score_r <= best_score_nxt;
  end

  assign busy      = state_r != imptab_pkg::FSM_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef SYNTHESIS
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CW'(ENTRIES))
    else $error("id counter beyond table size");

  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != imptab_pkg::FSM_IDLE))
    else $error("result beat without a command in flight");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == imptab_pkg::FSM_DECODE)
    else $error("accepted beat not decoded");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == imptab_pkg::FSM_SCAN |-> (rd_idx_r <= fresh_r && rd_idx_r != '0))
    else $error("scan index out of range");
`endif

endmodule

// ===== bench/imptab_result_checker.sv =====
`timescale 1ns / 100ps

module imptab_result_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  imptab_pkg::in_beat_t  in_cmd,
  input  logic                  out_valid,
  input  imptab_pkg::out_beat_t out_res,
  output int                    fail_count,
  output int                    pending
);

  localparam int          TABLE_DEPTH = 64;
  localparam int          FIFO_DEPTH  = 8;
  localparam logic [15:0] SCORE_TOP   = 16'hFFFF;

  logic [31:0]           payload_mem [TABLE_DEPTH];
  logic [15:0]           score_mem   [TABLE_DEPTH];
  logic                  live_mem    [TABLE_DEPTH];
  int                    fresh_count;
  imptab_pkg::out_beat_t want_fifo [FIFO_DEPTH];
  int                    wr_ptr;
  int                    rd_ptr;

  initial begin
    fail_count = 0;
    pending    = 0;
    wr_ptr     = 0;
    rd_ptr     = 0;
  end

  task automatic report(input string msg);
    $display("imptab check at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic imptab_pkg::out_beat_t table_step(input imptab_pkg::in_beat_t cmd);
    imptab_pkg::out_beat_t r;
    int                    best;
    int                    k;
    r = '0;
    case (cmd.opcode)
      imptab_pkg::OP_ADD: begin
        if (fresh_count >= TABLE_DEPTH) begin
          r.status = imptab_pkg::ST_FULL;
        end else begin
          k              = fresh_count;
          payload_mem[k] = cmd.payload;
          score_mem[k]   = '0;
          live_mem[k]    = 1'b1;
          fresh_count++;
          r.result_id = 6'(k);
          r.is_live   = 1'b1;
        end
      end
      imptab_pkg::OP_PROMOTE, imptab_pkg::OP_GET: begin
        k = int'(cmd.entry_id);
        if (!live_mem[k]) begin
          r.status = imptab_pkg::ST_DEAD;
        end else begin
          if (cmd.opcode == imptab_pkg::OP_PROMOTE && score_mem[k] != SCORE_TOP) begin
            score_mem[k] = score_mem[k] + 16'd1;
          end
          r.result_id      = cmd.entry_id;
          r.result_payload = payload_mem[k];
          r.result_score   = score_mem[k];
          r.is_live        = 1'b1;
        end
      end
      imptab_pkg::OP_GET_MAX, imptab_pkg::OP_POP_MAX: begin
        best = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (live_mem[i] && (best < 0 || score_mem[i] >= score_mem[best])) begin
            best = i;
          end
        end
        if (best < 0) begin
          r.status = imptab_pkg::ST_EMPTY;
        end else begin
          r.result_id      = 6'(best);
          r.result_payload = payload_mem[best];
          r.result_score   = score_mem[best];
          r.is_live        = (cmd.opcode == imptab_pkg::OP_GET_MAX);
          if (cmd.opcode == imptab_pkg::OP_POP_MAX) begin
            live_mem[best] = 1'b0;
          end
        end
      end
      imptab_pkg::OP_IS_VALID: begin
        r.result_id = cmd.entry_id;
        r.is_live   = live_mem[int'(cmd.entry_id)];
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    imptab_pkg::out_beat_t want;
    if (!rst_n) begin
      wr_ptr      = 0;
      rd_ptr      = 0;
      fresh_count = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        live_mem[i] = 1'b0;
      end
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (wr_ptr == rd_ptr) begin
          report("result beat with nothing pending");
        end else begin
          want = want_fifo[rd_ptr % FIFO_DEPTH];
          rd_ptr++;
          if (out_res.status !== want.status) begin
            report($sformatf("status got %0d want %0d", out_res.status, want.status));
          end
          if (out_res.result_id !== want.result_id) begin
            report($sformatf("result_id got %0d want %0d",
                             out_res.result_id, want.result_id));
          end
          if (out_res.result_payload !== want.result_payload) begin
            report($sformatf("result_payload got %h want %h",
                             out_res.result_payload, want.result_payload));
          end
          if (out_res.result_score !== want.result_score) begin
            report($sformatf("result_score got %0d want %0d",
                             out_res.result_score, want.result_score));
          end
          if (out_res.is_live !== want.is_live) begin
            report($sformatf("is_live got %b want %b", out_res.is_live, want.is_live));
          end
        end
      end
      if (start && !busy) begin
        want = table_step(in_cmd);
        if (wr_ptr - rd_ptr >= FIFO_DEPTH) begin
          report("too many beats in flight");
        end else begin
          want_fifo[wr_ptr % FIFO_DEPTH] = want;
          wr_ptr++;
        end
      end
      pending <= wr_ptr - rd_ptr;
    end
  end

endmodule

// ===== bench/tb_indexed_max_priority_table.sv =====
`timescale 1ns / 100ps

module tb_indexed_max_priority_table;

  localparam logic [2:0] OP_SPARE_6   = 3'd6;
  localparam logic [2:0] OP_SPARE_7   = 3'd7;
  localparam int         QUIET_LIMIT  = 1000;
  localparam int         RANDOM_BEATS = 1200;
  localparam int         CALM_BEATS   = 200;
  localparam int         DRAIN_CYCLES = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  imptab_pkg::in_beat_t  in_cmd;
  logic                  out_valid;
  imptab_pkg::out_beat_t out_res;
  int                    fail_count;
  int                    pending;
  int                    quiet_cycles;
  int                    adds_issued;
  bit                    gaps_on;

  indexed_max_priority_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  imptab_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_indexed_max_priority_table: errors");
        $finish;
      end
    end
  end

  task automatic issue(input logic [2:0] op, input logic [5:0] id, input logic [31:0] pay);
    imptab_pkg::in_beat_t beat;
    beat.opcode   = op;
    beat.entry_id = id;
    beat.payload  = pay;
    in_cmd <= beat;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == imptab_pkg::OP_ADD && adds_issued < 64) begin
      adds_issued++;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [5:0] pick_id();
    if (adds_issued > 0 && $urandom_range(0, 3) != 0) begin
      return 6'($urandom_range(0, adds_issued - 1));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    int          pick;
    logic [2:0]  op;
    quiet_cycles = 0;
    adds_issued  = 0;
    gaps_on      = 1'b1;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_cmd <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unissued ids, spare opcodes
    issue(imptab_pkg::OP_GET_MAX, 6'd0, 32'h0);
    issue(imptab_pkg::OP_POP_MAX, 6'd63, 32'hFFFF_FFFF);
    issue(imptab_pkg::OP_GET, 6'd0, 32'h0);
    issue(imptab_pkg::OP_PROMOTE, 6'd63, 32'h0);
    issue(imptab_pkg::OP_IS_VALID, 6'd63, 32'h0);
    issue(OP_SPARE_6, 6'd0, 32'h0);
    issue(OP_SPARE_7, 6'd63, 32'hFFFF_FFFF);
    // adds, ties, promote, pop, dead ids
    issue(imptab_pkg::OP_ADD, 6'd63, 32'h0);
    issue(imptab_pkg::OP_ADD, 6'd0, 32'hFFFF_FFFF);
    issue(imptab_pkg::OP_ADD, 6'd21, 32'hA5A5_A5A5);
    issue(imptab_pkg::OP_GET_MAX, 6'd0, 32'h0);
    issue(imptab_pkg::OP_PROMOTE, 6'd0, 32'h0);
    issue(imptab_pkg::OP_PROMOTE, 6'd1, 32'h0);
    issue(imptab_pkg::OP_PROMOTE, 6'd1, 32'h0);
    issue(imptab_pkg::OP_GET, 6'd1, 32'h0);
    issue(imptab_pkg::OP_IS_VALID, 6'd1, 32'h0);
    issue(imptab_pkg::OP_POP_MAX, 6'd0, 32'h0);
    issue(imptab_pkg::OP_GET, 6'd1, 32'h0);
    issue(imptab_pkg::OP_PROMOTE, 6'd1, 32'h0);
    issue(imptab_pkg::OP_IS_VALID, 6'd1, 32'h0);
    issue(imptab_pkg::OP_PROMOTE, 6'd2, 32'h0);
    issue(imptab_pkg::OP_GET_MAX, 6'd0, 32'h0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      gaps_on = (n < RANDOM_BEATS - CALM_BEATS) && ($urandom_range(0, 4) != 0 || n % 100 > 30);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        op = imptab_pkg::OP_ADD;
      end else if (pick < 45) begin
        op = imptab_pkg::OP_PROMOTE;
      end else if (pick < 57) begin
        op = imptab_pkg::OP_GET_MAX;
      end else if (pick < 63) begin
        op = imptab_pkg::OP_POP_MAX;
      end else if (pick < 75) begin
        op = imptab_pkg::OP_IS_VALID;
      end else if (pick < 93) begin
        op = imptab_pkg::OP_GET;
      end else if (pick < 96) begin
        op = OP_SPARE_6;
      end else begin
        op = OP_SPARE_7;
      end
      issue(op, pick_id(), $urandom);
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_indexed_max_priority_table: clean");
    end else begin
      $display("tb_indexed_max_priority_table: errors");
    end
    $finish;
  end

endmodule
